@@ rtl/text_console_writer_core_assert.svh @@
// Assertion macros used by the console writer core.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every clock edge outside reset.
`define TCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TCW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TCW_ASSERT(label, prop, msg)
`define TCW_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ rtl/tcw_pkg.sv @@
// Shared types and constants of the text console writer.
// No dependencies; the interfaces and the core import this package.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int POS_COL_W  = 7;
    localparam int POS_ROW_W  = 5;
    localparam int CELL_W     = 16;
    localparam int LIN_W      = 11;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd2;

    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F00;

    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_RDWAIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ rtl/tcw_if.sv @@
// Valid/ready channel interfaces of the text console writer: commands, results, configuration.
// Depends on tcw_pkg for field widths.
`default_nettype none

interface tcw_cmd_if;
    import tcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [CHAR_W-1:0]    character;
    logic [POS_COL_W-1:0] pos_column;
    logic [POS_ROW_W-1:0] pos_row;

    modport source (output valid, output command, output character, output pos_column,
                    output pos_row, input ready);
    modport sink   (input valid, input command, input character, input pos_column,
                    input pos_row, output ready);
endinterface

interface tcw_res_if;
    import tcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_data;
    logic [POS_COL_W-1:0] cursor_column;
    logic [POS_ROW_W-1:0] cursor_row;
    logic [LIN_W-1:0]     cursor_linear;
    logic                 did_scroll;

    modport source (output valid, output cell_data, output cursor_column, output cursor_row,
                    output cursor_linear, output did_scroll, input ready);
    modport sink   (input valid, input cell_data, input cursor_column, input cursor_row,
                    input cursor_linear, input did_scroll, output ready);
endinterface

interface tcw_cfg_if;
    import tcw_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/text_console_writer_core.sv @@
// Top level of the text console writer: cursor control, scroll logic and the cell buffer.
// Depends on tcw_pkg, the tcw_*_if interfaces, tcw_ram and the assertion macro header.
//
// Usage. Commands arrive as words on the cmd channel (write character, read cell, set
// cursor) and every command produces exactly one result word on the res channel, carrying
// the cursor after the command, its linear position and, for a read, the cell contents.
// Colors are set through the cfg channel, which is always ready; write it only while the
// block is idle.
// Flow. A command is taken into an internal register and executed in the next cycle; its
// result is then loaded into the output register from ST_DONE once that register is
// free, and a new command can be accepted in that same cycle. A read also waits in
// ST_RDWAIT for the registered read data of the cell memory. A tab is four space writes,
// one per cycle unless a scroll comes between them. The screen is a ring of rows
// addressed through a top row pointer, so a scroll only rotates the pointer and blanks
// the bottom row that comes in, one cell per cycle through the single memory write port.
// Reset. After rst_n is released all ROWS*COLUMNS cells (2000 by default) are blanked,
// one cell per cycle; cmd is held not ready meanwhile.
// Stalls. The result sits in an output register; while the receiver stalls, the block may
// take and execute one more command, then holds it until the output register frees up.
`default_nettype none
`include "text_console_writer_core_assert.svh"

module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    tcw_cmd_if.sink   cmd,
    tcw_res_if.source res,
    tcw_cfg_if.sink   cfg
);
    import tcw_pkg::*;

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    // Control and architectural state.
    state_t              state_reg, state_next;
    logic [CW-1:0]       cur_col_reg, cur_col_next;
    logic [RW-1:0]       cur_row_reg, cur_row_next;
    logic [RW-1:0]       top_reg, top_next;
    logic [1:0]          steps_reg, steps_next;
    logic [AW-1:0]       sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]       sweep_last_reg, sweep_last_next;
    logic [COLOR_W-1:0]  fg_reg, bg_reg;
    logic                out_valid_reg;

    // Latched command and per-command result state.
    logic [CMD_W-1:0]     op_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic [POS_COL_W-1:0] pcol_reg;
    logic [POS_ROW_W-1:0] prow_reg;
    logic [CELL_W-1:0]    cell_reg, cell_next;
    logic                 scroll_reg, scroll_next;

    // Output register.
    logic [CELL_W-1:0]    out_cell_reg;
    logic [POS_COL_W-1:0] out_col_reg;
    logic [POS_ROW_W-1:0] out_row_reg;
    logic [LIN_W-1:0]     out_lin_reg;
    logic                 out_scroll_reg;

    // Memory port signals.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic cmd_ready;
    logic accept;
    logic out_free;
    logic load_out;

    // Datapath helpers.
    logic [CHAR_W-1:0] step_char;
    logic [CW:0]       col_inc;
    logic              at_last_row;
    logic [RW-1:0]     top_inc;
    logic [AW-1:0]     top_base;
    logic [RW:0]       cur_sum, rd_sum;
    logic [RW-1:0]     cur_phys, rd_phys;
    logic [CW-1:0]     clamp_col;
    logic [RW-1:0]     clamp_row;
    logic [AW-1:0]     cur_addr, rd_addr;
    logic [AW-1:0]     cur_lin;
    logic [AW-1:0]     fill_left;

    assign out_free  = !out_valid_reg || res.ready;
    assign cmd_ready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
    assign accept    = cmd.valid && cmd_ready;
    assign cmd.ready = cmd_ready;
    assign cfg.ready = 1'b1;

    // A tab is executed as spaces; everything else steps with its own code.
    assign step_char   = (char_reg == CH_TAB) ? CH_SPACE : char_reg;
    assign col_inc     = {1'b0, cur_col_reg} + 1'b1;
    assign at_last_row = (cur_row_reg == RW'(ROWS - 1));
    assign top_inc     = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + 1'b1;
    assign top_base    = AW'(top_reg) * AW'(COLUMNS);

    // Requested position, saturated to the screen.
    assign clamp_col = (8'(pcol_reg) > 8'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(pcol_reg);
    assign clamp_row = (8'(prow_reg) > 8'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(prow_reg);

    // Logical rows map onto physical rows of the ring starting at the top pointer.
    assign cur_sum  = {1'b0, cur_row_reg} + {1'b0, top_reg};
    assign rd_sum   = {1'b0, clamp_row} + {1'b0, top_reg};
    assign cur_phys = (cur_sum >= (RW+1)'(ROWS)) ? RW'(cur_sum - (RW+1)'(ROWS)) : RW'(cur_sum);
    assign rd_phys  = (rd_sum >= (RW+1)'(ROWS)) ? RW'(rd_sum - (RW+1)'(ROWS)) : RW'(rd_sum);
    assign cur_addr = AW'(cur_phys) * AW'(COLUMNS) + AW'(cur_col_reg);
    assign rd_addr  = AW'(rd_phys) * AW'(COLUMNS) + AW'(clamp_col);

    // Linear cursor position as the display controller sees it.
    assign cur_lin = AW'(cur_row_reg) * AW'(COLUMNS) + AW'(cur_col_reg);

    // Cells still to be blanked by a sweep, less one.
    assign fill_left = sweep_last_reg - sweep_addr_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        top_next        = top_reg;
        steps_next      = steps_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        cell_next       = cell_reg;
        scroll_next     = scroll_reg;
        ram_we          = 1'b0;
        ram_waddr       = sweep_addr_reg;
        ram_wdata       = BLANK_CELL;
        ram_re          = 1'b0;
        ram_raddr       = rd_addr;
        load_out        = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_EXEC;
                    cell_next   = '0;
                    scroll_next = 1'b0;
                    steps_next  = ((cmd.command == CMD_WRITE) && (cmd.character == CH_TAB))
                                  ? 2'd3 : 2'd0;
                end
            end

            ST_EXEC:
            begin
                case (op_reg)
                    CMD_WRITE:
                    begin
                        logic advance;
                        logic scrolled;
                        advance  = 1'b0;
                        scrolled = 1'b0;
                        if (step_char == CH_NEWLINE)
                        begin
                            cur_col_next = '0;
                            advance      = 1'b1;
                        end
                        else if (step_char == CH_RETURN)
                        begin
                            cur_col_next = '0;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cur_addr;
                            ram_wdata = {bg_reg, fg_reg, step_char};
                            if (col_inc == (CW+1)'(COLUMNS))
                            begin
                                cur_col_next = '0;
                                advance      = 1'b1;
                            end
                            else
                            begin
                                cur_col_next = col_inc[CW-1:0];
                            end
                        end
                        if (advance)
                        begin
                            if (at_last_row)
                            begin
                                // The old top row comes back in at the bottom and is blanked.
                                scrolled        = 1'b1;
                                scroll_next     = 1'b1;
                                top_next        = top_inc;
                                sweep_addr_next = top_base;
                                sweep_last_next = top_base + AW'(COLUMNS - 1);
                            end
                            else
                            begin
                                cur_row_next = cur_row_reg + 1'b1;
                            end
                        end
                        // After a scroll the count of spaces still owed is kept as it is,
                        // and the fill takes one off when it hands back to execution.
                        if ((steps_reg != 2'd0) && !scrolled)
                        begin
                            steps_next = steps_reg - 1'b1;
                        end
                        if (scrolled)
                        begin
                            state_next = ST_FILL;
                        end
                        else if (steps_reg != 2'd0)
                        begin
                            state_next = ST_EXEC;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end

                    CMD_READ:
                    begin
                        ram_re     = 1'b1;
                        state_next = ST_RDWAIT;
                    end

                    CMD_SET:
                    begin
                        cur_col_next = clamp_col;
                        cur_row_next = clamp_row;
                        state_next   = ST_DONE;
                    end

                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_FILL:
            begin
                ram_we = 1'b1;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    if (steps_reg != 2'd0)
                    begin
                        // A tab that scrolled partway through goes on with its other spaces.
                        steps_next = steps_reg - 1'b1;
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end

            ST_RDWAIT:
            begin
                cell_next  = ram_rdata;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (accept)
                    begin
                        state_next  = ST_EXEC;
                        cell_next   = '0;
                        scroll_next = 1'b0;
                        steps_next  = ((cmd.command == CMD_WRITE) && (cmd.character == CH_TAB))
                                      ? 2'd3 : 2'd0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cur_col_reg    <= '0;
            cur_row_reg    <= RW'(ROWS - 1);
            top_reg        <= '0;
            steps_reg      <= '0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= AW'(DEPTH - 1);
            fg_reg         <= FG_RESET;
            bg_reg         <= BG_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            top_reg        <= top_next;
            steps_reg      <= steps_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_FOREGROUND)
                begin
                    fg_reg <= cfg.data;
                end
                else if (cfg.index == CFG_BACKGROUND)
                begin
                    bg_reg <= cfg.data;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cell_reg   <= cell_next;
        scroll_reg <= scroll_next;
        if (accept)
        begin
            op_reg   <= cmd.command;
            char_reg <= cmd.character;
            pcol_reg <= cmd.pos_column;
            prow_reg <= cmd.pos_row;
        end
        if (load_out)
        begin
            out_cell_reg   <= cell_reg;
            out_col_reg    <= POS_COL_W'(cur_col_reg);
            out_row_reg    <= POS_ROW_W'(cur_row_reg);
            out_lin_reg    <= LIN_W'(cur_lin);
            out_scroll_reg <= scroll_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.cell_data     = out_cell_reg;
    assign res.cursor_column = out_col_reg;
    assign res.cursor_row    = out_row_reg;
    assign res.cursor_linear = out_lin_reg;
    assign res.did_scroll    = out_scroll_reg;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    `TCW_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> !(res.valid || cmd.ready), "busy in reset")
    `TCW_ASSERT(a_col_on_screen, cur_col_reg <= CW'(COLUMNS - 1), "cursor column off screen")
    `TCW_ASSERT(a_row_on_screen, cur_row_reg <= RW'(ROWS - 1), "cursor row off screen")
    `TCW_ASSERT(a_top_on_screen, top_reg <= RW'(ROWS - 1), "top row pointer off screen")
    `TCW_ASSERT(a_read_before_capture, state_reg == ST_RDWAIT |-> $past(ram_re), "no read")
    `TCW_ASSERT(a_fill_one_row, state_reg == ST_FILL |-> fill_left < AW'(COLUMNS), "long fill")

endmodule

`default_nettype wire

@@ rtl/tcw_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No package dependencies.
`default_nettype none

module tcw_ram #(
    parameter int   WIDTH = 16,
    parameter int   DEPTH = 2000,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
